FILE: hw/rtl/sbl_pkg.sv
`timescale 1ns / 1ps

package sbl_pkg;

    // longest line taken in, in bytes
    localparam int MAX_LINE = 256;

    // bytes_seen must hold MAX_LINE itself
    localparam int SEEN_W = $clog2(MAX_LINE + 1);

    localparam int CNT_W = 9;
    localparam int POS_W = 8;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef struct packed {
        logic             write_valid;
        logic             target;
        logic [POS_W-1:0] position;
        logic [7:0]       char_value;
        logic             done_res;
        logic             status;
        logic [CNT_W-1:0] interp_len;
        logic [CNT_W-1:0] arg_len;
        logic             has_arg;
    } res_t;

endpackage

FILE: hw/rtl/shebang_line_parser.sv
`timescale 1ns / 1ps

// Shebang line parser. Takes the bytes of a script's first line (after the
// "#!" prefix), one beat per byte, and for each beat returns one result beat
// that says whether the byte is stored into the interpreter name (target 0)
// or the single unsplit argument (target 1), and at which position. Leading
// blanks and the blanks between interpreter and argument are dropped; a
// newline or NUL byte, or reaching MAX_LINE bytes, ends the line and later
// bytes are ignored. The beat flagged last carries done_res together with the
// interpreter length, the argument length with trailing blanks stripped,
// has_arg and status (1 for a blank line), and returns the parser to its
// start state. Throughput is one beat per clock while in_stall is low: the
// parse state and the result are worked out in one pass of short logic and
// the result is registered in the output register. A skid register behind
// the output register lets the block take one more beat while the output
// is stalled; in_stall is raised only when that skid slot is full.
module shebang_line_parser
    import sbl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,

    // input beat channel
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             present,
    input  logic [7:0]       line_byte,
    input  logic             last,

    // result beat channel
    output logic             out_valid,
    input  logic             out_stall,
    output logic             write_valid,
    output logic             target,
    output logic [POS_W-1:0] position,
    output logic [7:0]       char_value,
    output logic             done_res,
    output logic             status,
    output logic [CNT_W-1:0] interp_len,
    output logic [CNT_W-1:0] arg_len,
    output logic             has_arg
);

    // parse phases
    localparam logic [1:0] PH_LEAD   = 2'd0;
    localparam logic [1:0] PH_INTERP = 2'd1;
    localparam logic [1:0] PH_GAP    = 2'd2;
    localparam logic [1:0] PH_ARG    = 2'd3;

    // parse state
    logic [1:0]        phase_reg, phase_next;
    logic              line_ended_reg, line_ended_next;
    logic [SEEN_W-1:0] bytes_seen_reg, bytes_seen_next;
    logic [CNT_W-1:0]  interp_count_reg, interp_count_next;
    logic [CNT_W-1:0]  arg_count_reg, arg_count_next;
    logic [CNT_W-1:0]  arg_trim_reg, arg_trim_next;

    // output register and skid slot
    logic              out_valid_reg;
    res_t              out_reg;
    logic              skid_valid_reg;
    res_t              skid_reg;

    res_t              res;
    logic              in_fire;
    logic              out_fire;
    logic              is_blank;
    logic              is_term;
    logic              under_max;
    logic              take;
    logic [1:0]        phase_upd;

    assign in_stall = skid_valid_reg;
    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid_reg && !out_stall;

    assign is_blank  = (line_byte == CH_SPACE) || (line_byte == CH_TAB);
    assign is_term   = (line_byte == CH_LF) || (line_byte == CH_NUL);
    assign under_max = bytes_seen_reg < SEEN_W'(MAX_LINE);

    // a byte is stored only while the line is still open
    assign take = present && !line_ended_reg && !is_term && under_max;

    always_comb
    begin
        priority if (phase_reg == PH_LEAD && !is_blank)
        begin
            phase_upd = PH_INTERP;
        end
        else if (phase_reg == PH_GAP && !is_blank)
        begin
            phase_upd = PH_ARG;
        end
        else if (phase_reg == PH_INTERP && is_blank)
        begin
            phase_upd = PH_GAP;
        end
        else
        begin
            phase_upd = phase_reg;
        end
    end

    always_comb
    begin
        phase_next        = phase_reg;
        line_ended_next   = line_ended_reg;
        bytes_seen_next   = bytes_seen_reg;
        interp_count_next = interp_count_reg;
        arg_count_next    = arg_count_reg;
        arg_trim_next     = arg_trim_reg;
        res               = '0;

        // newline, NUL or a full line closes it
        if (present && !line_ended_reg && !take)
        begin
            line_ended_next = 1'b1;
        end

        if (take)
        begin
            bytes_seen_next = bytes_seen_reg + SEEN_W'(1);
            phase_next      = phase_upd;

            if (phase_upd == PH_INTERP && !is_blank)
            begin
                res.write_valid   = 1'b1;
                res.target        = 1'b0;
                res.position      = (interp_count_reg < CNT_W'(POS_MAX)) ?
                                    interp_count_reg[POS_W-1:0] : POS_MAX;
                res.char_value    = line_byte;
                interp_count_next = (interp_count_reg != CNT_MAX) ?
                                    interp_count_reg + CNT_W'(1) : CNT_MAX;
            end
            else if (phase_upd == PH_ARG)
            begin
                res.write_valid = 1'b1;
                res.target      = 1'b1;
                res.position    = (arg_count_reg < CNT_W'(POS_MAX)) ?
                                  arg_count_reg[POS_W-1:0] : POS_MAX;
                res.char_value  = line_byte;
                arg_count_next  = (arg_count_reg != CNT_MAX) ?
                                  arg_count_reg + CNT_W'(1) : CNT_MAX;
                // trailing blanks do not move the trimmed length
                if (!is_blank)
                begin
                    arg_trim_next = arg_count_next;
                end
            end
        end

        // the last beat reports totals, then the parser starts afresh
        if (last)
        begin
            res.done_res      = 1'b1;
            res.status        = (interp_count_next == '0);
            res.interp_len    = interp_count_next;
            res.arg_len       = arg_trim_next;
            res.has_arg       = (arg_trim_next != '0);
            phase_next        = PH_LEAD;
            line_ended_next   = 1'b0;
            bytes_seen_next   = '0;
            interp_count_next = '0;
            arg_count_next    = '0;
            arg_trim_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_LEAD;
            line_ended_reg   <= 1'b0;
            bytes_seen_reg   <= '0;
            interp_count_reg <= '0;
            arg_count_reg    <= '0;
            arg_trim_reg     <= '0;
        end
        else if (in_fire)
        begin
            phase_reg        <= phase_next;
            line_ended_reg   <= line_ended_next;
            bytes_seen_reg   <= bytes_seen_next;
            interp_count_reg <= interp_count_next;
            arg_count_reg    <= arg_count_next;
            arg_trim_reg     <= arg_trim_next;
        end
    end

    // output register with skid slot behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || out_fire)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= in_fire;
                end
            end
            else if (in_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (in_fire)
            begin
                out_reg <= res;
            end
        end
        else if (in_fire)
        begin
            skid_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign write_valid = out_reg.write_valid;
    assign target      = out_reg.target;
    assign position    = out_reg.position;
    assign char_value  = out_reg.char_value;
    assign done_res    = out_reg.done_res;
    assign status      = out_reg.status;
    assign interp_len  = out_reg.interp_len;
    assign arg_len     = out_reg.arg_len;
    assign has_arg     = out_reg.has_arg;

`ifndef SYNTHESIS
    // skid slot only fills behind a held output beat
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot full while output register empty");

    // a last beat returns the parser to its start state
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && last |=> phase_reg == PH_LEAD && bytes_seen_reg == '0 &&
                            !line_ended_reg && interp_count_reg == '0 &&
                            arg_trim_reg == '0)
        else $error("parse state not cleared after last beat");

    // trimmed length never runs ahead of the argument count
    a_trim_bound: assert property (@(posedge clk) disable iff (!rst_n)
        arg_trim_reg <= arg_count_reg)
        else $error("trimmed argument length above argument count");

    // status flags a blank line exactly when no interpreter byte was seen
    a_status_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_res |-> status == (interp_len == '0))
        else $error("status disagrees with interpreter length");

    // nothing is stored once the line has ended
    a_no_write_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && line_ended_reg |-> !res.write_valid)
        else $error("byte stored after end of line");
`endif

endmodule
